/* rtl/core/avgp_pkg.sv */
package avgp_pkg;

  // coordinate arithmetic on 11-bit sides plus padding and window overhang
  localparam int CORD_W = 13;

  localparam int HW_W  = 11;
  localparam int K_W   = 4;
  localparam int P_W   = 2;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAD    = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/core/avgp_div.sv */
module avgp_div #(
  parameter int DW = 23,
  parameter int VW = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [VW-1:0]       divisor_i,
  output logic [DW-1:0]       quotient_o,
  output avgp_pkg::div_stat_t stat_o
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [VW:0]      rem_sh;
  logic             ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CNT_W'(DW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? VW'(rem_sh - {1'b0, divisor_i}) : rem_sh[VW-1:0];
      quo_d  = {quo_q[DW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

/* rtl/core/avg_pool_2d_exclude_pad_unit.sv */
// Channel   | Dir | Handshake               | Payload
// cfg       | in  | cfg_we_i                | cfg_idx_i, cfg_wdata_i
// s_axis    | in  | s_axis_tvalid/tready    | tdata: sample
// m_axis    | out | m_axis_tvalid/tready    | tdata: average, out_row, out_col;
//           |     |                         | tlast: last_of_run; tuser: plane_done, shape_error
//
// An item is taken only in the idle state; a pixel that closes no window is
// done when it is taken. Each closed window passes through a setup state, one
// store read per in-window sample (up to MAX_WINDOW^2), a drain state, a
// divider start state, the serial divider wait and an emit state; no item is
// taken until the run of windows ends. The row store read port and the serial
// divider limit how fast windows are produced.
// Reset returns registers to 8, 8, 2, 2, 0 and positions to zero; the store is
// not cleared. A stalled output only holds the next window in the emit state.
module avg_pool_2d_exclude_pad_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 2 * avgp_pkg::HW_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [avgp_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [avgp_pkg::HW_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,   // sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata,   // average, out_row, out_col
  output logic                           m_axis_tlast,
  output logic [1:0]                     m_axis_tuser    // plane_done, shape_error
);

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW     = $clog2(MAX_WINDOW + 1);
  localparam int NW     = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW);
  localparam int DW     = SUM_W + 1;
  localparam int CD     = avgp_pkg::CORD_W;
  localparam int HW     = avgp_pkg::HW_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_SUM    = 7'b0000100,
    ST_SUMW   = 7'b0001000,
    ST_DSTART = 7'b0010000,
    ST_DWAIT  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [HW-1:0]               cfg_h_q, cfg_w_q;
  logic [avgp_pkg::K_W-1:0]    cfg_k_q, cfg_s_q;
  logic [avgp_pkg::P_W-1:0]    cfg_p_q;

  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [SW-1:0] slot_q;
  logic          init_q;
  logic [HW-1:0] ridx_q, cidx_q;
  logic [CD-1:0] rclose_q, cclose_q;

  logic [HW-1:0] em_oy_q, em_ox_q, first_ox_q;
  logic [CD-1:0] em_rclose_q, em_cclose_q, first_cclose_q;
  logic          em_rmulti_q, em_cmulti_q, err_q;
  logic [RW-1:0] acc_row_q;
  logic [SW-1:0] acc_slot_q;

  logic [SW-1:0] y_slot_q;
  logic [CW-1:0] x_q, cs_q, ce_q;
  logic [KW-1:0] rows_left_q;
  logic [NW-1:0] n_q;

  logic signed [SUM_W-1:0]       acc_q;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic                          rd_pend_q;

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW][MAX_WIDTH];

  logic             m_tvalid_q;
  logic [OUT_W-1:0] m_tdata_q;
  logic             m_tlast_q;
  logic [1:0]       m_tuser_q;

  // configuration view
  logic [CD-1:0] h13, w13, k13, s13, p13, hp, wp, kp0;
  logic          cfg_ok;

  always_comb begin
    h13 = CD'(cfg_h_q);
    w13 = CD'(cfg_w_q);
    k13 = CD'(cfg_k_q);
    s13 = CD'(cfg_s_q);
    p13 = CD'(cfg_p_q);
    hp  = h13 + p13;
    wp  = w13 + p13;
    kp0 = k13 - CD'(1) - p13;
    cfg_ok = (h13 >= CD'(1)) && (h13 <= CD'(MAX_HEIGHT)) &&
             (w13 >= CD'(1)) && (w13 <= CD'(MAX_WIDTH)) &&
             (k13 >= CD'(1)) && (k13 <= CD'(MAX_WINDOW)) &&
             (s13 >= CD'(1)) && ((p13 << 1) <= k13) &&
             (h13 + (p13 << 1) >= k13) && (w13 + (p13 << 1) >= k13);
  end

  // closing test for the incoming pixel
  logic [HW-1:0] e_ridx, e_cidx;
  logic [CD-1:0] e_rclose, e_cclose;
  logic          r_last, c_last, r_hit, c_hit, s_fire;

  always_comb begin
    e_ridx   = init_q ? '0 : ridx_q;
    e_cidx   = init_q ? '0 : cidx_q;
    e_rclose = init_q ? kp0 : rclose_q;
    e_cclose = init_q ? kp0 : cclose_q;
    r_last   = CD'(row_q) == h13 - CD'(1);
    c_last   = CD'(col_q) == w13 - CD'(1);
    // a window beyond the last output index never closes
    r_hit    = (e_rclose + CD'(1) <= hp) && (r_last || e_rclose == CD'(row_q));
    c_hit    = (e_cclose + CD'(1) <= wp) && (c_last || e_cclose == CD'(col_q));
    s_fire   = s_axis_tvalid && s_axis_tready;
  end

  // window bounds, clamped to the image
  logic signed [CD:0] rtop, ctop;
  logic [CD-1:0]      rs, re, cs, ce, nrows, ncols;
  logic [SW:0]        row_dist, slot0;

  always_comb begin
    rtop  = $signed({1'b0, em_rclose_q}) - $signed({1'b0, k13 - CD'(1)});
    ctop  = $signed({1'b0, em_cclose_q}) - $signed({1'b0, k13 - CD'(1)});
    rs    = rtop[CD] ? '0 : rtop[CD-1:0];
    cs    = ctop[CD] ? '0 : ctop[CD-1:0];
    re    = (em_rclose_q > h13 - CD'(1)) ? h13 - CD'(1) : em_rclose_q;
    ce    = (em_cclose_q > w13 - CD'(1)) ? w13 - CD'(1) : em_cclose_q;
    nrows = re - rs + CD'(1);
    ncols = ce - cs + CD'(1);
    row_dist = (SW + 1)'(CD'(acc_row_q) - rs);
    slot0 = ({1'b0, acc_slot_q} >= row_dist) ? {1'b0, acc_slot_q} - row_dist
                                             : {1'b0, acc_slot_q} + (SW + 1)'(MAX_WINDOW)
                                               - row_dist;
  end

  logic [SW-1:0] slot_inc, y_slot_inc;
  assign slot_inc   = (slot_q == SW'(MAX_WINDOW - 1)) ? '0 : slot_q + 1'b1;
  assign y_slot_inc = (y_slot_q == SW'(MAX_WINDOW - 1)) ? '0 : y_slot_q + 1'b1;

  // divider
  logic                    div_start;
  logic [SUM_W-1:0]        mag;
  logic [DW-1:0]           dividend, quotient;
  avgp_pkg::div_stat_t     div_stat;

  assign div_start = (state_q == ST_DSTART);
  assign mag       = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
  assign dividend  = {1'b0, mag} + DW'(n_q >> 1);

  avgp_div #(
    .DW (DW),
    .VW (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (n_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // emit decisions
  logic                   out_free, c_more, r_more, plane_end;
  logic [SAMPLE_BITS-1:0] avg;

  always_comb begin
    out_free  = !m_tvalid_q || m_axis_tready;
    c_more    = em_cmulti_q && (em_cclose_q + s13 + CD'(1) <= wp);
    r_more    = em_rmulti_q && (em_rclose_q + s13 + CD'(1) <= hp);
    plane_end = !(em_rclose_q + s13 + CD'(1) <= hp) && !(em_cclose_q + s13 + CD'(1) <= wp);
    avg       = acc_q[SUM_W-1] ? SAMPLE_BITS'(-quotient) : quotient[SAMPLE_BITS-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (!cfg_ok)              state_d = ST_EMIT;
          else if (r_hit && c_hit)  state_d = ST_SETUP;
        end
      end
      ST_SETUP:  state_d = ST_SUM;
      ST_SUM: begin
        if (rows_left_q == KW'(1) && x_q == ce_q) state_d = ST_SUMW;
      end
      ST_SUMW:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_stat.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (err_q || (!c_more && !r_more)) state_d = ST_IDLE;
          else                               state_d = ST_SETUP;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_h_q    <= HW'(8);
      cfg_w_q    <= HW'(8);
      cfg_k_q    <= avgp_pkg::K_W'(2);
      cfg_s_q    <= avgp_pkg::K_W'(2);
      cfg_p_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
      slot_q     <= '0;
      init_q     <= 1'b1;
      ridx_q     <= '0;
      cidx_q     <= '0;
      rclose_q   <= '0;
      cclose_q   <= '0;
      err_q      <= 1'b0;
      rd_pend_q  <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == ST_SUM);

      if (cfg_we_i && cfg_idx_i <= avgp_pkg::REG_PAD) begin
        case (cfg_idx_i)
          avgp_pkg::REG_HEIGHT: cfg_h_q <= cfg_wdata_i;
          avgp_pkg::REG_WIDTH:  cfg_w_q <= cfg_wdata_i;
          avgp_pkg::REG_WINDOW: cfg_k_q <= cfg_wdata_i[avgp_pkg::K_W-1:0];
          avgp_pkg::REG_STEP:   cfg_s_q <= cfg_wdata_i[avgp_pkg::K_W-1:0];
          avgp_pkg::REG_PAD:    cfg_p_q <= cfg_wdata_i[avgp_pkg::P_W-1:0];
          default:              cfg_p_q <= cfg_p_q;
        endcase
        row_q  <= '0;
        col_q  <= '0;
        slot_q <= '0;
        init_q <= 1'b1;
      end else if (s_fire) begin
        if (!cfg_ok) begin
          row_q  <= '0;
          col_q  <= '0;
          slot_q <= '0;
          init_q <= 1'b1;
          err_q  <= 1'b1;
        end else begin
          init_q <= 1'b0;
          err_q  <= 1'b0;
          if (c_last) begin
            col_q    <= '0;
            cidx_q   <= '0;
            cclose_q <= kp0;
            if (r_last) begin
              row_q    <= '0;
              slot_q   <= '0;
              ridx_q   <= '0;
              rclose_q <= kp0;
            end else begin
              row_q  <= row_q + 1'b1;
              slot_q <= slot_inc;
              if (e_rclose == CD'(row_q)) begin
                ridx_q   <= e_ridx + 1'b1;
                rclose_q <= e_rclose + s13;
              end else begin
                ridx_q   <= e_ridx;
                rclose_q <= e_rclose;
              end
            end
          end else begin
            col_q    <= col_q + 1'b1;
            ridx_q   <= e_ridx;
            rclose_q <= e_rclose;
            if (e_cclose == CD'(col_q)) begin
              cidx_q   <= e_cidx + 1'b1;
              cclose_q <= e_cclose + s13;
            end else begin
              cidx_q   <= e_cidx;
              cclose_q <= e_cclose;
            end
          end
        end
      end

      if (state_q == ST_EMIT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // window walk and accumulation
  always_ff @(posedge clk_i) begin
    if (s_fire && cfg_ok) begin
      em_oy_q        <= e_ridx;
      em_ox_q        <= e_cidx;
      first_ox_q     <= e_cidx;
      em_rclose_q    <= e_rclose;
      em_cclose_q    <= e_cclose;
      first_cclose_q <= e_cclose;
      em_rmulti_q    <= r_last;
      em_cmulti_q    <= c_last;
      acc_row_q      <= row_q;
      acc_slot_q     <= slot_q;
    end

    case (state_q)
      ST_SETUP: begin
        y_slot_q    <= slot0[SW-1:0];
        x_q         <= cs[CW-1:0];
        cs_q        <= cs[CW-1:0];
        ce_q        <= ce[CW-1:0];
        rows_left_q <= nrows[KW-1:0];
        n_q         <= NW'(nrows[KW-1:0]) * NW'(ncols[KW-1:0]);
        acc_q       <= '0;
      end
      ST_SUM: begin
        if (x_q == ce_q) begin
          x_q         <= cs_q;
          y_slot_q    <= y_slot_inc;
          rows_left_q <= rows_left_q - 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (err_q) begin
            m_tdata_q <= '0;
            m_tlast_q <= 1'b1;
            m_tuser_q <= 2'b10;
          end else begin
            m_tdata_q <= OUT_W'({em_ox_q, em_oy_q, avg});
            m_tuser_q <= {1'b0, plane_end};
            m_tlast_q <= !c_more && !r_more;
            if (c_more) begin
              em_ox_q     <= em_ox_q + 1'b1;
              em_cclose_q <= em_cclose_q + s13;
            end else if (r_more) begin
              em_oy_q     <= em_oy_q + 1'b1;
              em_rclose_q <= em_rclose_q + s13;
              em_ox_q     <= first_ox_q;
              em_cclose_q <= first_cclose_q;
            end
          end
        end
      end
      default: begin
        if (rd_pend_q) acc_q <= acc_q + SUM_W'(rd_data_q);
      end
    endcase
    if (state_q == ST_SUM && rd_pend_q) acc_q <= acc_q + SUM_W'(rd_data_q);
  end

  // row store
  always_ff @(posedge clk_i) begin
    if (s_fire && cfg_ok) mem[slot_q][col_q] <= s_axis_tdata[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) rd_data_q <= mem[y_slot_q][x_q];
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;
  assign m_axis_tuser  = m_tuser_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DWAIT)
    else $error("divider finished outside the wait state");

  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> !rd_pend_q && !div_stat.busy)
    else $error("item accepted while a window is in progress");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tuser_q[1]) |-> m_tlast_q)
    else $error("error result not marked last");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int SB = 16;
  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXK = 8;

  typedef struct packed {
    logic signed [SB-1:0] average;
    logic [10:0] out_row;
    logic [10:0] out_col;
    logic plane_done;
    logic last_of_run;
    logic shape_error;
  } pool_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [avgp_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [avgp_pkg::HW_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [1:0] m_axis_tuser;

  avg_pool_2d_exclude_pad_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  int img_h, img_w, win, stp, pad;
  int cur_row, cur_col;
  int signed line_buf [MAXK*MAXW];

  logic [15:0] sample_q[$];
  pool_res_t want_q[$];
  int errors = 0;
  bit hold_off = 0;

  function automatic bit shape_ok();
    if (img_h < 1 || img_h > MAXH || img_w < 1 || img_w > MAXW) return 0;
    if (win < 1 || win > MAXK || stp < 1 || 2*pad > win) return 0;
    if (img_h + 2*pad < win || img_w + 2*pad < win) return 0;
    return 1;
  endfunction

  function automatic bit closes(int pos, int sz, output int lo, output int hi);
    int cnt, t;
    cnt = (sz + 2*pad - win) / stp + 1;
    t = pos + pad + 1 - win;
    if (pos < sz - 1) begin
      if (t < 0 || (t % stp) != 0) return 0;
      lo = t / stp;
      hi = lo;
    end else begin
      lo = (t <= 0) ? 0 : (t + stp - 1) / stp;
      hi = cnt - 1;
    end
    return lo <= hi && hi <= cnt - 1;
  endfunction

  function automatic logic signed [SB-1:0] mean_of(int oy, int ox);
    int rs, re, cs, ce;
    longint sum, n, mag, q;
    rs = oy*stp - pad; re = rs + win - 1;
    cs = ox*stp - pad; ce = cs + win - 1;
    if (rs < 0) rs = 0;
    if (re > img_h-1) re = img_h-1;
    if (cs < 0) cs = 0;
    if (ce > img_w-1) ce = img_w-1;
    if (re < rs || ce < cs) return '0;
    sum = 0;
    for (int y = rs; y <= re; y++)
      for (int x = cs; x <= ce; x++)
        sum += line_buf[(y % MAXK)*MAXW + x];
    n = (re-rs+1)*(ce-cs+1);
    mag = (sum < 0) ? -sum : sum;
    q = (mag + n/2) / n;
    return SB'((sum < 0) ? -q : q);
  endfunction

  task automatic pool_pixel(logic [15:0] smp);
    pool_res_t r;
    int rlo, rhi, clo, chi, hout, wout, n;
    if (!shape_ok()) begin
      cur_row = 0; cur_col = 0;
      r = '0; r.last_of_run = 1; r.shape_error = 1;
      want_q.push_back(r);
      return;
    end
    line_buf[(cur_row % MAXK)*MAXW + cur_col] = $signed(smp);
    hout = (img_h + 2*pad - win) / stp + 1;
    wout = (img_w + 2*pad - win) / stp + 1;
    n = 0;
    if (closes(cur_row, img_h, rlo, rhi) && closes(cur_col, img_w, clo, chi)) begin
      for (int oy = rlo; oy <= rhi; oy++)
        for (int ox = clo; ox <= chi && n < 16; ox++) begin
          r = '0;
          r.average = mean_of(oy, ox);
          r.out_row = 11'(oy);
          r.out_col = 11'(ox);
          r.plane_done = (oy == hout-1 && ox == wout-1);
          want_q.push_back(r);
          n++;
        end
      if (n > 0) want_q[$].last_of_run = 1;
    end
    cur_col++;
    if (cur_col >= img_w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= img_h) cur_row = 0;
    end
  endtask

  task automatic report(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pool_pixel(s_axis_tdata);
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
    end
    if (s_axis_tvalid && !s_axis_tready) begin
      // keep offering
    end else if (gap > 0) begin
      gap--;
      s_axis_tvalid <= 1'b0;
    end else if (sample_q.size() > 0 && rst_ni) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= sample_q.pop_front();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk_i) begin
    pool_res_t g, e;
    if (m_axis_tvalid && m_axis_tready) begin
      g.average = m_axis_tdata[15:0];
      g.out_row = m_axis_tdata[26:16];
      g.out_col = m_axis_tdata[37:27];
      g.last_of_run = m_axis_tlast;
      g.plane_done = m_axis_tuser[0];
      g.shape_error = m_axis_tuser[1];
      if (want_q.size() == 0) begin
        report("unexpected result", g.out_row, -1);
      end else begin
        e = want_q.pop_front();
        if (g.average !== e.average) report("average", g.average, e.average);
        if (g.out_row !== e.out_row) report("out_row", g.out_row, e.out_row);
        if (g.out_col !== e.out_col) report("out_col", g.out_col, e.out_col);
        if (g.plane_done !== e.plane_done) report("plane_done", g.plane_done, e.plane_done);
        if (g.last_of_run !== e.last_of_run)
          report("last_of_run", g.last_of_run, e.last_of_run);
        if (g.shape_error !== e.shape_error)
          report("shape_error", g.shape_error, e.shape_error);
      end
      stall = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) stall = 0;
    end
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [avgp_pkg::IDX_W-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= avgp_pkg::HW_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      avgp_pkg::REG_HEIGHT: img_h = val & 32'h7ff;
      avgp_pkg::REG_WIDTH:  img_w = val & 32'h7ff;
      avgp_pkg::REG_WINDOW: win = val & 32'hf;
      avgp_pkg::REG_STEP:   stp = val & 32'hf;
      default:              pad = val & 32'h3;
    endcase
    cur_row = 0;
    cur_col = 0;
  endtask

  task automatic settle();
    wait (sample_q.size() == 0 && !s_axis_tvalid);
    wait (want_q.size() == 0);
    repeat (1500) @(posedge clk_i);
  endtask

  task automatic set_shape(int h, int w, int k, int s, int p);
    settle();
    write_reg(avgp_pkg::REG_HEIGHT, h);
    write_reg(avgp_pkg::REG_WIDTH, w);
    write_reg(avgp_pkg::REG_WINDOW, k);
    write_reg(avgp_pkg::REG_STEP, s);
    write_reg(avgp_pkg::REG_PAD, p);
  endtask

  task automatic add_plane(int npix);
    for (int i = 0; i < npix; i++) sample_q.push_back(16'($urandom));
  endtask

  initial begin
    img_h = 8; img_w = 8; win = 2; stp = 2; pad = 0;
    cur_row = 0; cur_col = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes on reset shape
    sample_q.push_back(16'h8000); sample_q.push_back(16'h7fff);
    sample_q.push_back(16'h7fff); sample_q.push_back(16'h8000);
    sample_q.push_back(16'hffff); sample_q.push_back(16'h0001);
    sample_q.push_back(16'h0000); sample_q.push_back(16'h8000);
    // padded corners: one pixel closes many windows
    set_shape(3, 3, 4, 1, 2);
    add_plane(9);
    // unusable shapes
    set_shape(3, 3, 2, 1, 2);
    add_plane(2);
    set_shape(1, 1, 8, 1, 3);
    add_plane(2);
    set_shape(0, 5, 2, 0, 0);
    add_plane(2);
    // large width, one-pixel window
    set_shape(1, 1024, 1, 8, 0);
    add_plane(3);
    // long hold-off: the block must stall its input
    set_shape(4, 4, 3, 1, 1);
    hold_off = 1;
    add_plane(16);
    repeat (3000) @(posedge clk_i);
    hold_off = 0;
    // random shapes, small sizes
    for (int ph = 0; ph < 12; ph++) begin
      int k, p;
      k = $urandom_range(1, 8);
      p = $urandom_range(0, 3);
      if (2*p > k && ph % 4 != 3) p = k / 2;
      set_shape($urandom_range(1, 5), $urandom_range(1, 5), k,
                $urandom_range(1, 8), p);
      add_plane($urandom_range(7, 18));
    end
    set_shape(1024, 2, 2, 3, 1);
    add_plane(6);
    settle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

endmodule
